>>> sv/point_to_scan_binner_assert.svh
// Assertion macros used by the point to scan binner controller.
`ifndef POINT_TO_SCAN_BINNER_ASSERT_SVH
`define POINT_TO_SCAN_BINNER_ASSERT_SVH
`ifndef SYNTHESIS
`define PTSB_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("point_to_scan_binner: check failed");
`define PTSB_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("point_to_scan_binner: check failed");
`else
`define PTSB_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define PTSB_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> sv/ptsb_pkg.sv
// Package: types, constants and the arctangent table of the point to scan binner.
`default_nettype none
package ptsb_pkg;

    localparam int MAX_BINS     = 1024;
    localparam int ADDR_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 19;
    localparam int DIV_STEPS    = 18;
    localparam int CW           = 22;
    localparam int ZW           = 26;
    localparam int CNT_W        = 5;

    localparam logic signed [ZW-1:0] QUARTER_TURN = 26'sd4194304;
    localparam logic [25:0]          PI_Q24       = 26'd52707179;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_APERTURE = 3'd1,
        ST_HEIGHT   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_BEYOND   = 3'd4,
        ST_READ     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_START = 3'd0,
        REG_END   = 3'd1,
        REG_STEP  = 3'd2,
        REG_NEAR  = 3'd3,
        REG_FAR   = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_NONE, PH_CLEAR, PH_LOAD, PH_PRE, PH_SQY, PH_ITER, PH_ROUND,
        PH_MUL1, PH_MUL2, PH_CHECK, PH_DIV, PH_WRITE, PH_RD, PH_OUT
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [CNT_W-1:0]   cnt;
        logic [ADDR_W-1:0]  clr_addr;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic rejected;
    } t_dp_stat;

    function automatic logic signed [ZW-1:0] atan_tab(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 26'sd2097152;
            4'd1:    v = 26'sd1238021;
            4'd2:    v = 26'sd654136;
            4'd3:    v = 26'sd332050;
            4'd4:    v = 26'sd166669;
            4'd5:    v = 26'sd83416;
            4'd6:    v = 26'sd41718;
            4'd7:    v = 26'sd20860;
            4'd8:    v = 26'sd10430;
            4'd9:    v = 26'sd5215;
            4'd10:   v = 26'sd2608;
            4'd11:   v = 26'sd1304;
            4'd12:   v = 26'sd652;
            4'd13:   v = 26'sd326;
            4'd14:   v = 26'sd163;
            default: v = 26'sd81;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> sv/ptsb_if.sv
// Channel interfaces: point/read items in, scan results out.
`default_nettype none
interface ptsb_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic signed [17:0] pz;
    logic [9:0]         read_bin;
    modport source (output valid, op, px, py, pz, read_bin, input ready);
    modport sink   (input valid, op, px, py, pz, read_bin, output ready);
endinterface

interface ptsb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  bin_index;
    logic [17:0] range_value;
    modport source (output valid, status, bin_index, range_value, input ready);
    modport sink   (input valid, status, bin_index, range_value, output ready);
endinterface
`default_nettype wire

>>> sv/ptsb_ctrl.sv
// Controller: sequences clear pass, point processing and bin reads.
`default_nettype none
`include "point_to_scan_binner_assert.svh"
module ptsb_ctrl
    import ptsb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PRE, S_SQY, S_ITER, S_ROUND, S_MUL1, S_MUL2,
        S_CHECK, S_DIV, S_WRITE, S_RD, S_FIN
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_clr;
    logic              r_out_valid;
    logic              w_acc;
    logic              w_load_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_load_out  = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.cnt      = r_cnt;
        o_cmd.clr_addr = r_clr;
        unique case (r_state)
            S_CLEAR: o_cmd.phase = PH_CLEAR;
            S_IDLE:  o_cmd.phase = w_acc ? PH_LOAD : PH_NONE;
            S_PRE:   o_cmd.phase = PH_PRE;
            S_SQY:   o_cmd.phase = PH_SQY;
            S_ITER:  o_cmd.phase = PH_ITER;
            S_ROUND: o_cmd.phase = PH_ROUND;
            S_MUL1:  o_cmd.phase = PH_MUL1;
            S_MUL2:  o_cmd.phase = PH_MUL2;
            S_CHECK: o_cmd.phase = PH_CHECK;
            S_DIV:   o_cmd.phase = i_stat.rejected ? PH_NONE : PH_DIV;
            S_WRITE: o_cmd.phase = PH_WRITE;
            S_RD:    o_cmd.phase = PH_RD;
            S_FIN:   o_cmd.phase = w_load_out ? PH_OUT : PH_NONE;
            default: o_cmd.phase = PH_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MAX_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_state <= i_stat.op ? S_RD : S_SQY;
                end
                S_SQY: begin
                    r_cnt   <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ROUND: r_state <= S_MUL1;
                S_MUL1:  r_state <= S_MUL2;
                S_MUL2:  r_state <= S_CHECK;
                S_CHECK: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_stat.rejected) begin
                        r_state <= S_FIN;
                    end else if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WRITE: r_state <= S_FIN;
                S_RD:    r_state <= S_FIN;
                S_FIN: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PTSB_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, w_acc, !o_in_ready)
    `PTSB_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.phase == PH_OUT, !r_out_valid || i_out_ready)
    `PTSB_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == S_ITER, r_cnt < CNT_W'(SQRT_STEPS))
    `PTSB_ASSERT_IMP(a_clear_closed, i_clk, i_rst_n, r_state == S_CLEAR, !o_in_ready)

endmodule
`default_nettype wire

>>> sv/ptsb_dp.sv
// Datapath: CORDIC bearing, square root distance, tests, divider, bin store.
`default_nettype none
module ptsb_dp
    import ptsb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [17:0]        i_cfg_data,
    input  wire logic               i_rst_n,
    input  wire logic               i_op,
    input  wire logic signed [17:0] i_px,
    input  wire logic signed [17:0] i_py,
    input  wire logic signed [17:0] i_pz,
    input  wire logic [9:0]         i_read_bin,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output logic [2:0]              o_status,
    output logic [9:0]              o_bin_index,
    output logic [17:0]             o_range_value
);

    logic signed [15:0] r_start, r_end;
    logic [14:0]        r_step;
    logic [17:0]        r_near, r_far;

    logic               r_op;
    logic signed [17:0] r_px, r_py, r_pz;
    logic [9:0]         r_rb;
    logic               r_orig;

    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [35:0]          r_sq;
    logic [35:0]          r_n;
    logic [36:0]          r_res, r_bit;
    logic signed [17:0]   r_ang;
    logic [17:0]          r_dist;
    logic [32:0]          r_sd;
    logic [58:0]          r_rhs;
    logic                 r_ap_bad;
    logic                 r_rej;
    t_status              r_status;
    logic [17:0]          r_num;
    logic [16:0]          r_rem;
    logic [17:0]          r_q;
    logic [17:0]          r_rd;

    logic [17:0] mem [MAX_BINS];

    logic signed [17:0]   w_mop;
    logic [35:0]          w_msq;
    logic signed [CW-1:0] w_xs, w_ys;
    logic signed [ZW-1:0] w_at, w_zr;
    logic [37:0]          w_tst;
    logic                 w_ge;
    logic [14:0]          w_stp;
    logic [15:0]          w_div;
    logic signed [19:0]   w_ang2, w_lo, w_hi, w_sv, w_nm;
    logic [17:0]          w_az;
    logic [58:0]          w_lhs;
    logic [17:0]          w_rem_sh;
    logic                 w_mem_we;
    logic [ADDR_W-1:0]    w_mem_wa;
    logic [17:0]          w_mem_wd;
    logic                 w_rb_ok;
    logic                 w_q_ok;

    assign o_stat.op       = r_op;
    assign o_stat.rejected = r_rej;

    assign w_mop  = (i_cmd.phase == PH_PRE) ? r_px : r_py;
    assign w_msq  = 36'(w_mop * w_mop);
    assign w_xs   = r_x >>> i_cmd.cnt[3:0];
    assign w_ys   = r_y >>> i_cmd.cnt[3:0];
    assign w_at   = atan_tab(i_cmd.cnt[3:0]);
    assign w_zr   = (r_z + ZW'(128)) >>> 8;
    assign w_tst  = {1'b0, r_res} + {1'b0, r_bit};
    assign w_ge   = {2'b00, r_n} >= w_tst;
    assign w_stp  = (r_step == '0) ? 15'd1 : r_step;
    assign w_div  = {w_stp, 1'b0};
    assign w_sv   = signed'(20'(w_stp));
    assign w_ang2 = 20'(r_ang) <<< 1;
    assign w_lo   = (20'(r_start) <<< 1) - w_sv;
    assign w_hi   = (20'(r_end) <<< 1) + w_sv;
    assign w_nm   = w_ang2 - (20'(r_start) <<< 1) + w_sv;
    assign w_az   = (r_pz < 0) ? 18'(-19'(r_pz)) : 18'(r_pz);
    assign w_lhs  = {1'b0, w_az, 40'd0};
    assign w_rem_sh = {r_rem, r_num[17]};
    assign w_rb_ok  = 32'(r_rb) < 32'(MAX_BINS);
    assign w_q_ok   = 32'(r_q) < 32'(MAX_BINS);

    always_comb begin
        w_mem_we = 1'b0;
        w_mem_wa = i_cmd.clr_addr;
        w_mem_wd = '0;
        if (i_cmd.phase == PH_CLEAR) begin
            w_mem_we = 1'b1;
        end else if (i_cmd.phase == PH_WRITE && w_q_ok) begin
            w_mem_we = 1'b1;
            w_mem_wa = ADDR_W'(r_q);
            w_mem_wd = r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_wa] <= w_mem_wd;
        end
        if (i_cmd.phase == PH_RD) begin
            r_rd <= mem[ADDR_W'(r_rb)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= -16'sd16384;
            r_end   <= 16'sd16384;
            r_step  <= 15'd64;
            r_near  <= 18'd0;
            r_far   <= 18'd262143;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_START: r_start <= signed'(i_cfg_data[15:0]);
                REG_END:   r_end   <= signed'(i_cfg_data[15:0]);
                REG_STEP:  r_step  <= i_cfg_data[14:0];
                REG_NEAR:  r_near  <= i_cfg_data;
                REG_FAR:   r_far   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= 1'b0;
            r_rej <= 1'b0;
        end else begin
            case (i_cmd.phase)
                PH_LOAD: begin
                    r_op  <= i_op;
                    r_px  <= i_px;
                    r_py  <= i_py;
                    r_pz  <= i_pz;
                    r_rb  <= i_read_bin;
                    r_rej <= 1'b0;
                end
                PH_PRE: begin
                    r_orig <= (r_px == '0) && (r_py == '0);
                    r_sq   <= w_msq;
                    if (r_px < 0) begin
                        if (r_py >= 0) begin
                            r_x <= CW'(r_py);
                            r_y <= -CW'(r_px);
                            r_z <= QUARTER_TURN;
                        end else begin
                            r_x <= -CW'(r_py);
                            r_y <= CW'(r_px);
                            r_z <= -QUARTER_TURN;
                        end
                    end else begin
                        r_x <= CW'(r_px);
                        r_y <= CW'(r_py);
                        r_z <= '0;
                    end
                end
                PH_SQY: begin
                    r_n   <= r_sq + w_msq;
                    r_res <= '0;
                    r_bit <= 37'(1) << 36;
                end
                PH_ITER: begin
                    if (i_cmd.cnt < CNT_W'(CORDIC_STEPS)) begin
                        if (r_y > 0) begin
                            r_x <= r_x + w_ys;
                            r_y <= r_y - w_xs;
                            r_z <= r_z + w_at;
                        end else begin
                            r_x <= r_x - w_ys;
                            r_y <= r_y + w_xs;
                            r_z <= r_z - w_at;
                        end
                    end
                    if (w_ge) begin
                        r_n   <= r_n - w_tst[35:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                PH_ROUND: begin
                    r_ang  <= r_orig ? 18'sd0 : 18'(w_zr);
                    r_dist <= 18'(r_res + 37'({1'b0, r_n} > r_res));
                end
                PH_MUL1: begin
                    r_sd     <= 33'(w_stp) * 33'(r_dist);
                    r_ap_bad <= (w_ang2 < w_lo) || (w_ang2 > w_hi);
                end
                PH_MUL2: begin
                    r_rhs <= 59'(r_sd) * 59'(PI_Q24);
                end
                PH_CHECK: begin
                    r_num <= 18'(w_nm);
                    r_rem <= '0;
                    r_q   <= '0;
                    if (r_ap_bad) begin
                        r_status <= ST_APERTURE;
                        r_rej    <= 1'b1;
                    end else if (w_lhs > r_rhs) begin
                        r_status <= ST_HEIGHT;
                        r_rej    <= 1'b1;
                    end else if (r_dist > r_far || r_dist < r_near) begin
                        r_status <= ST_RANGE;
                        r_rej    <= 1'b1;
                    end else begin
                        r_status <= ST_STORED;
                    end
                end
                PH_DIV: begin
                    r_num <= r_num << 1;
                    if (w_rem_sh >= 18'(w_div)) begin
                        r_rem <= 17'(w_rem_sh - 18'(w_div));
                        r_q   <= {r_q[16:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[16:0];
                        r_q   <= {r_q[16:0], 1'b0};
                    end
                end
                PH_WRITE: begin
                    r_status <= w_q_ok ? ST_STORED : ST_BEYOND;
                end
                PH_RD: begin
                    r_status <= w_rb_ok ? ST_READ : ST_BEYOND;
                end
                PH_OUT: begin
                    o_status <= r_status;
                    case (r_status)
                        ST_STORED: begin
                            o_bin_index   <= r_q[9:0];
                            o_range_value <= r_dist;
                        end
                        ST_READ: begin
                            o_bin_index   <= r_rb;
                            o_range_value <= r_rd;
                        end
                        default: begin
                            o_bin_index   <= '0;
                            o_range_value <= '0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/point_to_scan_binner.sv
// Top level of the point to scan binner.
`default_nettype none
// Bins 3D points into a 1024-bin virtual scan. An insert runs one loop of
// the 16-step CORDIC bearing beside the square-root distance, then multiplies
// and tests, then a restoring division by twice the bin step; a rejected point
// skips the division. A read goes through the registered port of the bin
// store. After reset a clearing pass over all MAX_BINS (1024) entries zeroes
// the store; no item is taken until it ends. One item is in flight at a time;
// a new item is taken while the previous result waits in the output register.
module point_to_scan_binner
    import ptsb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [17:0] i_cfg_data,
    ptsb_in_if.sink          i_in,
    ptsb_out_if.source       o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ptsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ptsb_dp u_dp (
        .i_clk         (i_clk),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rst_n       (i_rst_n),
        .i_op          (i_in.op),
        .i_px          (i_in.px),
        .i_py          (i_in.py),
        .i_pz          (i_in.pz),
        .i_read_bin    (i_in.read_bin),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_status      (o_out.status),
        .o_bin_index   (o_out.bin_index),
        .o_range_value (o_out.range_value)
    );

endmodule
`default_nettype wire

>>> tb/point_to_scan_binner_tb.sv
// Self-checking testbench for the point to scan binner: predicted bins against results.
`default_nettype none
module point_to_scan_binner_tb;
    import ptsb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               op;
        logic signed [17:0] px;
        logic signed [17:0] py;
        logic signed [17:0] pz;
        logic [9:0]         read_bin;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [9:0]  bin_index;
        logic [17:0] range_value;
    } t_scan_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [17:0] i_cfg_data = '0;

    ptsb_in_if  in_ch();
    ptsb_out_if out_ch();

    point_to_scan_binner i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item       pending_items[$];
    t_scan_res   expected_results[$];
    int unsigned error_count = 0;
    longint      cycle_count = 0;
    bit          quiet_phase = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;

    logic signed [15:0] mdl_start;
    logic signed [15:0] mdl_end;
    logic [14:0]        mdl_step;
    logic [17:0]        mdl_near;
    logic [17:0]        mdl_far;
    logic [17:0]        mdl_bins[MAX_BINS];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint cordic_bearing(longint x, longint y);
        longint z, nx, ny;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; z = 4194304;
            end else begin
                nx = -y; ny = x; z = -4194304;
            end
            x = nx; y = ny;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + floor_shift(y, i); ny = y - floor_shift(x, i);
                z += longint'(atan_tab(i[3:0]));
            end else begin
                nx = x - floor_shift(y, i); ny = y + floor_shift(x, i);
                z -= longint'(atan_tab(i[3:0]));
            end
            x = nx; y = ny;
        end
        return floor_shift(z + 128, 8);
    endfunction

    function automatic longint rounded_root(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 36;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        if (n > res) res++;
        return res;
    endfunction

    function automatic t_scan_res bin_point(t_item it);
        t_scan_res r;
        longint x, y, z, stp, ang, dst, bin;
        longint unsigned az, lim;
        r = '{ST_STORED, '0, '0};
        if (it.op) begin
            r.status = ST_READ;
            r.bin_index = it.read_bin;
            r.range_value = mdl_bins[it.read_bin];
            return r;
        end
        x = it.px; y = it.py; z = it.pz;
        stp = (mdl_step == 0) ? 1 : longint'(mdl_step);
        ang = cordic_bearing(x, y);
        dst = rounded_root(x * x + y * y);
        az = (z < 0) ? -z : z;
        lim = stp * dst * 52707179;
        if (2 * ang < 2 * longint'(mdl_start) - stp || 2 * ang > 2 * longint'(mdl_end) + stp)
            r.status = ST_APERTURE;
        else if ((az << 40) > lim)
            r.status = ST_HEIGHT;
        else if (dst > longint'(mdl_far) || dst < longint'(mdl_near))
            r.status = ST_RANGE;
        else begin
            bin = (2 * (ang - longint'(mdl_start)) + stp) / (2 * stp);
            if (bin >= MAX_BINS) r.status = ST_BEYOND;
            else begin
                mdl_bins[bin] = dst[17:0];
                r.bin_index = bin[9:0];
                r.range_value = dst[17:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_item it;
                it = pending_items.pop_front();
                expected_results.push_back(bin_point(it));
                in_ch.valid <= 1'b1;
                in_ch.op <= it.op; in_ch.px <= it.px; in_ch.py <= it.py;
                in_ch.pz <= it.pz; in_ch.read_bin <= it.read_bin;
                if (!quiet_phase && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 6);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", out_ch.status, -1);
                end else begin
                    t_scan_res e;
                    e = expected_results.pop_front();
                    if (out_ch.status !== e.status)
                        report_mismatch("status", out_ch.status, e.status);
                    if (out_ch.bin_index !== e.bin_index)
                        report_mismatch("bin_index", out_ch.bin_index, e.bin_index);
                    if (out_ch.range_value !== e.range_value)
                        report_mismatch("range_value", out_ch.range_value, e.range_value);
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                snk_gap <= $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0; in_ch.op = 1'b0; in_ch.px = '0; in_ch.py = '0;
        in_ch.pz = '0; in_ch.read_bin = '0; out_ch.ready = 1'b0;
        mdl_start = -16384; mdl_end = 16384; mdl_step = 64;
        mdl_near = 0; mdl_far = 18'h3FFFF;
        foreach (mdl_bins[i]) mdl_bins[i] = '0;
    end

    task automatic write_reg(t_reg_idx idx, logic [17:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_START: mdl_start = val[15:0];
            REG_END:   mdl_end = val[15:0];
            REG_STEP:  mdl_step = val[14:0];
            REG_NEAR:  mdl_near = val;
            default:   mdl_far = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic add_point(int x, int y, int z);
        t_item it;
        it = '{1'b0, x[17:0], y[17:0], z[17:0], 10'($urandom)};
        pending_items.push_back(it);
    endtask

    task automatic add_read(int b);
        t_item it;
        it = '{1'b1, 18'($urandom), 18'($urandom), 18'($urandom), b[9:0]};
        pending_items.push_back(it);
    endtask

    task automatic add_random(int n);
        int r, m;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            m = (1 << $urandom_range(4, 17)) - 1;
            if (r < 3) add_read($urandom_range(0, 1023));
            else if (r < 8) add_point($urandom_range(0, 2 * m) - m,
                    $urandom_range(0, 2 * m) - m, $urandom_range(0, 40) - 20);
            else add_point(int'($urandom) >>> 14, int'($urandom) >>> 14,
                    int'($urandom) >>> 14);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (1100) @(posedge i_clk);
        add_read(0); add_read(1023);
        add_point(0, 0, 0); add_point(131071, 0, 0); add_point(-131072, 0, 0);
        add_point(0, 131071, 0); add_point(0, -131072, 0); add_point(-131072, -131072, 0);
        add_point(131071, 131071, 0); add_point(-131072, 5, 0); add_point(-131072, -5, 0);
        add_point(1000, 0, 131071); add_point(1000, 0, -131072); add_point(1000, 0, 49);
        add_point(1000, 10, 0); add_read(0); add_read(512);
        wait_idle();
        write_reg(REG_START, 18'h08000); write_reg(REG_END, 18'h07FFF);
        write_reg(REG_STEP, 18'h0);      write_reg(REG_NEAR, 18'd100);
        write_reg(REG_FAR, 18'd50000);
        add_point(50, 0, 0); add_point(60000, 0, 0); add_point(-1000, 1, 0);
        add_point(-1000, -1, 0); add_random(100);
        wait_idle();
        write_reg(REG_STEP, 18'h7FFF); write_reg(REG_NEAR, 18'd0);
        write_reg(REG_FAR, 18'h3FFFF);
        add_random(100);
        wait_idle();
        write_reg(REG_START, 18'h01000); write_reg(REG_END, 18'h3F000);
        write_reg(REG_STEP, 18'd100);
        add_random(40);
        wait_idle();
        write_reg(REG_START, 18'h3E000); write_reg(REG_END, 18'h02000);
        write_reg(REG_STEP, 18'd16);
        add_random(100);
        wait_idle();
        quiet_phase = 1'b1;
        add_random(60);
        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
